@@ src/sarfc_pkg.sv @@
// shared field widths and register codes for the star attitude rotate and cull block
package sarfc_pkg;

	localparam int ID_W   = 17;
	localparam int VEC_W  = 18;
	localparam int MAG_W  = 13;
	localparam int CAMZ_W = 17;
	localparam int BRT_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;
	localparam int TDATA_W = 88;

	// log2(2.512) in q.16 and ln2 in q.30
	localparam longint LOG2_BASE = 87087;
	localparam longint LN2_Q30   = 744261118;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUAT_W    = 3'd0,
		REG_QUAT_X    = 3'd1,
		REG_QUAT_Y    = 3'd2,
		REG_QUAT_Z    = 3'd3,
		REG_MAX_BRT   = 3'd4,
		REG_FOV_X     = 3'd5,
		REG_FOV_Y     = 3'd6,
		REG_MAG_LIMIT = 3'd7
	} reg_idx_t;

endpackage

@@ src/star_attitude_rotate_fov_cull.sv @@
// star direction rotation by attitude quaternion with magnitude and field of view cull
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        star_id, star_x/y/z, star_magnitude
//  m_axis    out  m_axis_tvalid/tready        kept_id, cam_x/y, cam_z, brightness
//  cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data
//
// four register stages: hamilton product, second product and rounding with table
// lookup, fov and brightness multiplies, compare and shift into the output register.
// one star per cycle while the output is not stalled; culled stars leave no result.
// the stall chain runs back from m_axis_tready, so a stage only holds while full.
// reset clears the valid bits and loads the register defaults.
// EXP_TABLE_DEPTH must be a power of two.
module star_attitude_rotate_fov_cull
	import sarfc_pkg::*;
#(
	parameter int FRAC_BITS       = 16,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// star_id, star_x, star_y, star_z, star_magnitude, zero fill
	input  logic [TDATA_W-1:0]    s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// kept_id, cam_x, cam_y, cam_z, brightness, zero fill
	output logic [TDATA_W-1:0]    m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DB  = $clog2(EXP_TABLE_DEPTH);
	localparam int IW  = 2 * VEC_W + 2;
	localparam int RW  = IW + VEC_W + 3;
	localparam int CW  = RW - 2 * FRAC_BITS;
	localparam int XW  = CW + 18;
	localparam int PW  = 18 + CW + FRAC_BITS;
	localparam int EW  = MAG_W + 19 + DB;
	localparam int NW  = EW - 24;
	localparam int KW  = NW - DB;
	localparam int TW  = 31;
	localparam int VW  = BRT_W + TW;
	localparam int BW  = VW + 6;
	localparam longint CAM_MAX = (FRAC_BITS < 17) ? (64'sd1 <<< FRAC_BITS) : 64'sd131071;

	function automatic logic [TW-1:0] pow_entry(input int jj);
		logic [63:0] x;
		logic [63:0] t;
		logic [63:0] s;
		x = (64'(jj) * 64'(LN2_Q30) + 64'(EXP_TABLE_DEPTH / 2)) / EXP_TABLE_DEPTH;
		s = 64'd1 << 30;
		t = 64'd1 << 30;
		t = ((t * x) >> 30) / 64'd1;   s = s - t;
		t = ((t * x) >> 30) / 64'd2;   s = s + t;
		t = ((t * x) >> 30) / 64'd3;   s = s - t;
		t = ((t * x) >> 30) / 64'd4;   s = s + t;
		t = ((t * x) >> 30) / 64'd5;   s = s - t;
		t = ((t * x) >> 30) / 64'd6;   s = s + t;
		t = ((t * x) >> 30) / 64'd7;   s = s - t;
		t = ((t * x) >> 30) / 64'd8;   s = s + t;
		t = ((t * x) >> 30) / 64'd9;   s = s - t;
		t = ((t * x) >> 30) / 64'd10;  s = s + t;
		t = ((t * x) >> 30) / 64'd11;  s = s - t;
		t = ((t * x) >> 30) / 64'd12;  s = s + t;
		t = ((t * x) >> 30) / 64'd13;  s = s - t;
		return s[TW-1:0];
	endfunction

	logic [TW-1:0] pow_tab [EXP_TABLE_DEPTH];
	for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
		assign pow_tab[g] = pow_entry(g);
	end

	// configuration registers
	logic signed [VEC_W-1:0] qw_q, qx_q, qy_q, qz_q;
	logic [BRT_W-1:0]        max_brt_q;
	logic [17:0]             fov_x_q, fov_y_q;
	logic signed [MAG_W-1:0] mag_lim_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q      <= 18'sd65536;
			qx_q      <= '0;
			qy_q      <= '0;
			qz_q      <= '0;
			max_brt_q <= 16'd255;
			fov_x_q   <= 18'd32768;
			fov_y_q   <= 18'd32768;
			mag_lim_q <= 13'sd1536;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_QUAT_W:    qw_q      <= cfg_data;
				REG_QUAT_X:    qx_q      <= cfg_data;
				REG_QUAT_Y:    qy_q      <= cfg_data;
				REG_QUAT_Z:    qz_q      <= cfg_data;
				REG_MAX_BRT:   max_brt_q <= cfg_data[BRT_W-1:0];
				REG_FOV_X:     fov_x_q   <= cfg_data;
				REG_FOV_Y:     fov_y_q   <= cfg_data;
				REG_MAG_LIMIT: mag_lim_q <= cfg_data[MAG_W-1:0];
				default: ;
			endcase
		end
	end

	// stall chain
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	assign en4 = !v_s4 || m_axis_tready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1;

	// input unpack
	logic [ID_W-1:0]         in_id;
	logic signed [VEC_W-1:0] vx, vy, vz;
	logic signed [MAG_W-1:0] in_mag;
	assign in_id  = s_axis_tdata[16:0];
	assign vx     = s_axis_tdata[34:17];
	assign vy     = s_axis_tdata[52:35];
	assign vz     = s_axis_tdata[70:53];
	assign in_mag = s_axis_tdata[83:71];

	// stage 1: first quaternion product and brightness exponent
	logic signed [IW-1:0]    ix_s1, iy_s1, iz_s1, iw_s1;
	logic [ID_W-1:0]         id_s1;
	logic signed [NW-1:0]    n_s1;
	logic                    bright_ok_s1;
	logic signed [EW-1:0]    e_ed;
	logic signed [EW-1:0]    e_rnd;

	assign e_ed  = (EW'(in_mag) * EW'(18'sd87087)) <<< DB;
	assign e_rnd = e_ed + (EW'(1) <<< 23);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en1)
			v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ix_s1 <= qw_q * vx + qy_q * vz - qz_q * vy;
			iy_s1 <= qw_q * vy + qz_q * vx - qx_q * vz;
			iz_s1 <= qw_q * vz + qx_q * vy - qy_q * vx;
			iw_s1 <= -(qx_q * vx) - qy_q * vy - qz_q * vz;
			id_s1 <= in_id;
			n_s1  <= e_rnd[EW-1:24];
			bright_ok_s1 <= !(in_mag > mag_lim_q);
		end
	end

	// stage 2: second product, rounding, table read
	logic signed [RW-1:0] sx, sy, sz;
	logic signed [CW-1:0] x_s2, y_s2, z_s2;
	logic [ID_W-1:0]      id_s2;
	logic signed [KW-1:0] k_s2;
	logic [TW-1:0]        t_s2;
	logic                 ok_s2;
	logic [DB-1:0]        jn;

	assign sx = ix_s1 * qw_q - iw_s1 * qx_q - iy_s1 * qz_q + iz_s1 * qy_q
		+ (RW'(1) <<< (2 * FRAC_BITS - 1));
	assign sy = iy_s1 * qw_q - iw_s1 * qy_q - iz_s1 * qx_q + ix_s1 * qz_q
		+ (RW'(1) <<< (2 * FRAC_BITS - 1));
	assign sz = iz_s1 * qw_q - iw_s1 * qz_q - ix_s1 * qy_q + iy_s1 * qx_q
		+ (RW'(1) <<< (2 * FRAC_BITS - 1));
	assign jn = n_s1[DB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en2)
			v_s2 <= v_s1 && bright_ok_s1;
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			x_s2  <= sx[RW-1:2*FRAC_BITS];
			y_s2  <= sy[RW-1:2*FRAC_BITS];
			z_s2  <= sz[RW-1:2*FRAC_BITS];
			id_s2 <= id_s1;
			k_s2  <= n_s1[NW-1:DB];
			t_s2  <= pow_tab[jn];
			ok_s2 <= 1'b1;
		end
	end

	// stage 3: fov multiplies and brightness product
	logic signed [CW-1:0] x_s3, y_s3, z_s3;
	logic [CW-1:0]        ax_s3, ay_s3;
	logic [PW-1:0]        lxz_s3, lyz_s3;
	logic                 zpos_s3;
	logic [ID_W-1:0]      id_s3;
	logic [5:0]           sh_s3;
	logic [VW-1:0]        val_s3;
	logic [CW-1:0]        z_u;
	logic signed [KW+1:0] s_full;

	assign z_u    = z_s2[CW-1:0];
	assign s_full = (KW+2)'(k_s2) + (KW+2)'(30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en3)
			v_s3 <= v_s2 && ok_s2;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			z_s3    <= z_s2;
			ax_s3   <= x_s2[CW-1] ? CW'(-x_s2) : CW'(x_s2);
			ay_s3   <= y_s2[CW-1] ? CW'(-y_s2) : CW'(y_s2);
			lxz_s3  <= PW'(fov_x_q) * PW'(z_u);
			lyz_s3  <= PW'(fov_y_q) * PW'(z_u);
			zpos_s3 <= (z_s2 > 0);
			id_s3   <= id_s2;
			sh_s3   <= s_full[5:0];
			val_s3  <= VW'(max_brt_q) * VW'(t_s2);
		end
	end

	// stage 4: cull decision, brightness shift, saturation
	logic             keep;
	logic [BW-1:0]    brt_sum;
	logic [BW-1:0]    brt_res;
	logic [BRT_W-1:0] brt_sat;
	logic signed [XW-1:0] xe, ye, ze;
	logic signed [XW-1:0] xc, yc, zc;

	assign keep = zpos_s3
		&& !((PW'(ax_s3) << FRAC_BITS) > lxz_s3)
		&& !((PW'(ay_s3) << FRAC_BITS) > lyz_s3);

	assign brt_sum = BW'(val_s3) + (BW'(1) << (sh_s3 - 6'd1));
	assign brt_res = brt_sum >> sh_s3;
	assign brt_sat = (brt_res > BW'(65535)) ? 16'hffff : brt_res[BRT_W-1:0];

	assign xe = XW'(x_s3);
	assign ye = XW'(y_s3);
	assign ze = XW'(z_s3);
	assign xc = (xe > XW'(CAM_MAX)) ? XW'(CAM_MAX) : ((xe < -XW'(CAM_MAX)) ? -XW'(CAM_MAX) : xe);
	assign yc = (ye > XW'(CAM_MAX)) ? XW'(CAM_MAX) : ((ye < -XW'(CAM_MAX)) ? -XW'(CAM_MAX) : ye);
	assign zc = (ze > XW'(CAM_MAX)) ? XW'(CAM_MAX) : ze;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en4)
			v_s4 <= v_s3 && keep;
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			m_axis_tdata <= {2'b00, brt_sat, zc[CAMZ_W-1:0], yc[VEC_W-1:0],
				xc[VEC_W-1:0], id_s3};
		end
	end

	assign m_axis_tvalid = v_s4;

endmodule

@@ src/sarfc_checker.sv @@
// port-level checks for the star attitude rotate and cull block
module sarfc_checker
	import sarfc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tready,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// kept stars lie in front of the camera
	a_zpos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[69:53] != 17'd0)
		else $error("kept star with zero camera z");

	// saturation is symmetric, most negative code never shows
	a_xsat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[34:17] != 18'h20000 && m_axis_tdata[52:35] != 18'h20000)
		else $error("camera coordinate past saturation");

	// an empty output register never blocks input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");

endmodule

bind star_attitude_rotate_fov_cull sarfc_checker u_sarfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
